// ----- src/u8dhp_pkg.sv -----
// ----------------------------------------------------------------------------
// u8dhp_pkg
// Shared types, codes and lookup tables for the UTF-8 decoder with HTML
// input preprocessing: byte classes, the automaton transition table and
// the disallowed code point check.
// ----------------------------------------------------------------------------
`default_nettype none

package u8dhp_pkg;

   // Automaton state codes
   localparam logic [3:0] ST_ACCEPT = 4'd0;
   localparam logic [3:0] ST_REJECT = 4'd1;
   localparam logic [3:0] ST_LAST   = 4'd8;

   // Number of byte classes
   localparam logic [3:0] CLASS_COUNT = 4'd12;

   // Error kinds on the result channel
   localparam logic [1:0] ERR_NONE       = 2'd0;
   localparam logic [1:0] ERR_INVALID    = 2'd1;
   localparam logic [1:0] ERR_DISALLOWED = 2'd2;
   localparam logic [1:0] ERR_TRUNCATED  = 2'd3;

   // Code points with a special meaning
   localparam logic [20:0] CP_REPL = 21'h00FFFD;
   localparam logic [20:0] CP_LF   = 21'h00000A;
   localparam logic [20:0] CP_CR   = 21'h00000D;

   // Result slots of one item, in delivery order
   localparam int SLOT_COUNT = 3;
   localparam int SLOT_FIRST = 0;
   localparam int SLOT_RETRY = 1;
   localparam int SLOT_TRUNC = 2;

   // All results that one item causes; mask marks the slots in use
   typedef struct packed {
      logic [SLOT_COUNT-1:0]         mask;
      logic [SLOT_COUNT-1:0][20:0]   cp;
      logic [SLOT_COUNT-1:0][1:0]    err;
   } u8dhp_rec_type;

   // Outcome of a completed code point after preprocessing
   typedef struct packed {
      logic        emit;
      logic [20:0] cp;
      logic [1:0]  err;
      logic        is_cr;
   } u8dhp_finish_type;

   // Next state = TRANS_TABLE[state * 12 + class]
   localparam logic [3:0] TRANS_TABLE [0:107] = '{
      4'd0,4'd1,4'd2,4'd3,4'd5,4'd8,4'd7,4'd1,4'd1,4'd1,4'd4,4'd6,
      4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,
      4'd1,4'd0,4'd1,4'd1,4'd1,4'd1,4'd1,4'd0,4'd1,4'd0,4'd1,4'd1,
      4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd2,4'd1,4'd2,4'd1,4'd1,
      4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,
      4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd2,4'd1,4'd1,
      4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd3,4'd1,4'd3,4'd1,4'd1,
      4'd1,4'd3,4'd1,4'd1,4'd1,4'd1,4'd1,4'd3,4'd1,4'd3,4'd1,4'd1,
      4'd1,4'd3,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1
   };

   // Sort a raw byte into its class
   function automatic logic [3:0] byte_class(input logic [7:0] b);
      logic [3:0] c;
      begin
         if (b < 8'h80)       c = 4'd0;
         else if (b < 8'h90)  c = 4'd1;
         else if (b < 8'hA0)  c = 4'd9;
         else if (b < 8'hC0)  c = 4'd7;
         else if (b < 8'hC2)  c = 4'd8;
         else if (b < 8'hE0)  c = 4'd2;
         else if (b == 8'hE0) c = 4'd10;
         else if (b == 8'hED) c = 4'd4;
         else if (b < 8'hF0)  c = 4'd3;
         else if (b == 8'hF0) c = 4'd11;
         else if (b < 8'hF4)  c = 4'd6;
         else if (b == 8'hF4) c = 4'd5;
         else                 c = 4'd8;
         return c;
      end
   endfunction

   // Look up the transition; unknown states act as reject
   function automatic logic [3:0] next_state(input logic [3:0] s, input logic [3:0] c);
      logic [3:0] row;
      logic [6:0] idx;
      begin
         row = (s > ST_LAST) ? ST_REJECT : s;
         idx = 7'(row) * 7'(CLASS_COUNT) + 7'(c);
         if (c >= CLASS_COUNT) return ST_REJECT;
         return TRANS_TABLE[idx];
      end
   endfunction

   // Controls, C1 codes and noncharacters
   function automatic logic disallowed(input logic [20:0] c);
      begin
         return (c >= 21'h1 && c <= 21'h8) || (c == 21'hB) ||
                (c >= 21'hE && c <= 21'h1F) || (c >= 21'h7F && c <= 21'h9F) ||
                (c >= 21'hFDD0 && c <= 21'hFDEF) ||
                (c[15:0] == 16'hFFFE) || (c[15:0] == 16'hFFFF);
      end
   endfunction

   // Apply newline normalization and replacement to a finished code point
   function automatic u8dhp_finish_type finish_cp(input logic [20:0] c,
                                                  input logic lf_droppable);
      u8dhp_finish_type f;
      begin
         f.emit  = 1'b1;
         f.cp    = c;
         f.err   = ERR_NONE;
         f.is_cr = 1'b0;
         if (c == CP_CR) begin
            f.cp    = CP_LF;
            f.is_cr = 1'b1;
         end else if (c == CP_LF && lf_droppable) begin
            f.emit = 1'b0;
         end else if (disallowed(c)) begin
            f.cp  = CP_REPL;
            f.err = ERR_DISALLOWED;
         end
         return f;
      end
   endfunction

endpackage

`default_nettype wire

// ----- src/u8dhp_front.sv -----
// ----------------------------------------------------------------------------
// u8dhp_front
// Accepts one byte per cycle while the queue is not full, steps the decoding
// automaton (a second pass for a byte that breaks a sequence) and pushes the
// item's results as one record into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module u8dhp_front (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic [7:0]              req_in_byte,
   input  wire logic                    req_end_of_input,
   input  wire logic                    q_full,
   output logic                         q_push,
   output u8dhp_pkg::u8dhp_rec_type     q_push_rec
);
   import u8dhp_pkg::*;

   logic [3:0]  state_ff, state_in;
   logic [20:0] acc_ff, acc_in;
   logic        drop_ff, drop_in;

   logic             accept;
   logic [3:0]       cls;
   logic [7:0]       lead_mask;
   logic [20:0]      lead_acc;
   logic [20:0]      acc0;
   logic             was_start;
   logic [3:0]       ns0, ns1;
   logic [3:0]       mid_state;
   logic [20:0]      mid_acc;
   logic             mid_drop;
   u8dhp_finish_type fin0, fin1;
   u8dhp_rec_type    rec;

   // Stall on a full queue only
   assign accept    = req_valid && !q_full;
   assign req_stall = q_full;

   // Classify the byte and compute both candidate accumulators
   always_comb begin
      cls       = byte_class(req_in_byte);
      lead_mask = 8'hFF >> cls;
      lead_acc  = {13'd0, req_in_byte & lead_mask};
      was_start = (state_ff == ST_ACCEPT);
      acc0      = was_start ? lead_acc : {acc_ff[14:0], req_in_byte[5:0]};
      ns0       = next_state(state_ff, cls);
      ns1       = next_state(ST_ACCEPT, cls);
      fin0      = finish_cp(acc0, drop_ff && was_start);
      fin1      = finish_cp(lead_acc, drop_ff);
   end

   // Step the automaton and collect the results of this byte
   always_comb begin
      rec       = '0;
      mid_state = state_ff;
      mid_acc   = acc_ff;
      mid_drop  = 1'b0;
      if (ns0 == ST_ACCEPT) begin
         mid_state                = ST_ACCEPT;
         mid_acc                  = acc0;
         mid_drop                 = fin0.is_cr;
         rec.mask[SLOT_FIRST]     = fin0.emit;
         rec.cp[SLOT_FIRST]       = fin0.cp;
         rec.err[SLOT_FIRST]      = fin0.err;
      end else if (ns0 == ST_REJECT) begin
         mid_state                = ST_ACCEPT;
         mid_acc                  = '0;
         rec.mask[SLOT_FIRST]     = 1'b1;
         rec.cp[SLOT_FIRST]       = CP_REPL;
         rec.err[SLOT_FIRST]      = ERR_INVALID;
         // Redecode a rejected continuation byte as a new start
         if (!was_start) begin
            if (ns1 == ST_ACCEPT) begin
               mid_acc              = lead_acc;
               mid_drop             = fin1.is_cr;
               rec.mask[SLOT_RETRY] = fin1.emit;
               rec.cp[SLOT_RETRY]   = fin1.cp;
               rec.err[SLOT_RETRY]  = fin1.err;
            end else if (ns1 == ST_REJECT) begin
               rec.mask[SLOT_RETRY] = 1'b1;
               rec.cp[SLOT_RETRY]   = CP_REPL;
               rec.err[SLOT_RETRY]  = ERR_INVALID;
            end else begin
               mid_state            = ns1;
               mid_acc              = lead_acc;
            end
         end
      end else begin
         mid_state = ns0;
         mid_acc   = acc0;
      end
      // Flag a sequence left open at end of stream
      if (req_end_of_input && mid_state != ST_ACCEPT) begin
         rec.mask[SLOT_TRUNC] = 1'b1;
         rec.cp[SLOT_TRUNC]   = CP_REPL;
         rec.err[SLOT_TRUNC]  = ERR_TRUNCATED;
      end
   end

   // Advance state on accept; restart the stream after its last byte
   always_comb begin
      state_in = state_ff;
      acc_in   = acc_ff;
      drop_in  = drop_ff;
      if (accept) begin
         if (req_end_of_input) begin
            state_in = ST_ACCEPT;
            acc_in   = '0;
            drop_in  = 1'b0;
         end else begin
            state_in = mid_state;
            acc_in   = mid_acc;
            drop_in  = mid_drop;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACCEPT;
         acc_ff   <= '0;
         drop_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         acc_ff   <= acc_in;
         drop_ff  <= drop_in;
      end
   end

   // Push only items that cause at least one result
   assign q_push     = accept && (rec.mask != '0);
   assign q_push_rec = rec;

   a_no_reject_held: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_REJECT)
      else $error("reject state held");

   a_cr_leaves_accept: assert property (@(posedge clock) disable iff (reset)
      drop_ff |-> state_ff == ST_ACCEPT)
      else $error("CR flag set inside a sequence");

   a_eoi_restarts: assert property (@(posedge clock) disable iff (reset)
      (accept && req_end_of_input) |=> (state_ff == ST_ACCEPT && !drop_ff && acc_ff == '0))
      else $error("state not restarted after end of input");

endmodule

`default_nettype wire

// ----- src/u8dhp_queue.sv -----
// ----------------------------------------------------------------------------
// u8dhp_queue
// Short queue of result records between the decode front and the output
// back, so that either side can stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module u8dhp_queue #(
   parameter int DEPTH = 4
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire u8dhp_pkg::u8dhp_rec_type push_rec,
   input  wire logic                    pop,
   output logic                         full,
   output logic                         head_valid,
   output u8dhp_pkg::u8dhp_rec_type     head_rec
);
   import u8dhp_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   u8dhp_rec_type    entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_rec   = entry_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the record
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_rec;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count out of range");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("push into full queue");

   a_push_fills: assert property (@(posedge clock) disable iff (reset)
      (push && !do_pop) |=> head_valid)
      else $error("queue empty after push");

endmodule

`default_nettype wire

// ----- src/u8dhp_back.sv -----
// ----------------------------------------------------------------------------
// u8dhp_back
// Unrolls the head record into single results, one per cycle while the output
// is not stalled, through the output register; marks each item's last result.
// ----------------------------------------------------------------------------
`default_nettype none

module u8dhp_back (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    head_valid,
   input  wire u8dhp_pkg::u8dhp_rec_type head_rec,
   output logic                         pop,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic [20:0]                  rsp_code_point,
   output logic [1:0]                   rsp_error_kind,
   output logic                         rsp_last_of_run
);
   import u8dhp_pkg::*;

   logic [SLOT_COUNT-1:0] done_ff, done_in;
   logic                  valid_ff, valid_in;
   logic [20:0]           cp_ff, cp_in;
   logic [1:0]            err_ff, err_in;
   logic                  last_ff, last_in;

   logic [SLOT_COUNT-1:0] remaining;
   logic [SLOT_COUNT-1:0] sel;
   logic                  is_last;
   logic                  load;
   logic [20:0]           sel_cp;
   logic [1:0]            sel_err;

   // Pick the lowest slot not yet delivered
   always_comb begin
      remaining = head_rec.mask & ~done_ff;
      sel       = remaining & (~remaining + 1'b1);
      is_last   = ((remaining & ~sel) == '0);
      sel_cp    = '0;
      sel_err   = '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (sel[i]) begin
            sel_cp  = sel_cp | head_rec.cp[i];
            sel_err = sel_err | head_rec.err[i];
         end
      end
   end

   // Load the output register when it is empty or being taken
   assign load = head_valid && (!valid_ff || !rsp_stall);
   assign pop  = load && is_last;

   always_comb begin
      valid_in = valid_ff;
      cp_in    = cp_ff;
      err_in   = err_ff;
      last_in  = last_ff;
      done_in  = done_ff;
      if (load) begin
         valid_in = 1'b1;
         cp_in    = sel_cp;
         err_in   = sel_err;
         last_in  = is_last;
         done_in  = is_last ? '0 : (done_ff | sel);
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         done_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         done_ff  <= done_in;
      end
   end

   // Hold the payload
   always_ff @(posedge clock) begin
      cp_ff   <= cp_in;
      err_ff  <= err_in;
      last_ff <= last_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_code_point  = cp_ff;
   assign rsp_error_kind  = err_ff;
   assign rsp_last_of_run = last_ff;

   a_onehot_pick: assert property (@(posedge clock) disable iff (reset)
      (load && head_rec.mask != '0) |-> $onehot(sel))
      else $error("no single slot picked");

   a_done_subset: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> ((done_ff & ~head_rec.mask) == '0))
      else $error("delivered slot outside record");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_code_point) &&
         $stable(rsp_error_kind) && $stable(rsp_last_of_run)))
      else $error("stalled result changed");

endmodule

`default_nettype wire

// ----- src/utf8_decode_html_preprocess_unit.sv -----
// ----------------------------------------------------------------------------
// utf8_decode_html_preprocess_unit
// UTF-8 decoder with HTML newline normalization and code point replacement.
// An accepted byte's first result passes the record queue, then the output
// register. One byte per cycle while the queue is not full; the output
// register delivers one result per cycle while not stalled, and the record
// queue (QUEUE_DEPTH items) absorbs bytes that give more than one result.
// Reset: synchronous; clears automaton state, the CR flag, queue and output.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_decode_html_preprocess_unit #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_in_byte,
   input  wire logic        req_end_of_input,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [20:0]      rsp_code_point,
   output logic [1:0]       rsp_error_kind,
   output logic             rsp_last_of_run
);
   import u8dhp_pkg::*;

   logic          q_full;
   logic          q_push;
   u8dhp_rec_type q_push_rec;
   logic          q_pop;
   logic          q_head_valid;
   u8dhp_rec_type q_head_rec;

   // Decode bytes into result records
   u8dhp_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_byte      (req_in_byte),
      .req_end_of_input (req_end_of_input),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_push_rec       (q_push_rec)
   );

   // Buffer records between the two sides
   u8dhp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_rec   (q_push_rec),
      .pop        (q_pop),
      .full       (q_full),
      .head_valid (q_head_valid),
      .head_rec   (q_head_rec)
   );

   // Deliver results one at a time
   u8dhp_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (q_head_valid),
      .head_rec        (q_head_rec),
      .pop             (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_code_point  (rsp_code_point),
      .rsp_error_kind  (rsp_error_kind),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

`default_nettype wire
